/* sv/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/hti_pkg.sv */
// ----------------------------------------------------------------------------
// hti_pkg
// Shared types and constants of the heightmap triangle interpolator.
// ----------------------------------------------------------------------------
package hti_pkg;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_INV_STEP_X = 3'd2,
    REG_INV_STEP_Y = 3'd3,
    REG_DIV_X      = 3'd4,
    REG_DIV_Y      = 3'd5
  } reg_idx_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  node_x;
    logic [7:0]  node_y;
    logic [31:0] node_height;
    logic [31:0] point_x;
    logic [31:0] point_y;
  } in_word_t;

  typedef struct packed {
    logic [31:0] height;
    logic        upper_triangle;
  } out_word_t;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] inv_step_x;
    logic [31:0] inv_step_y;
    logic [7:0]  div_x;
    logic [7:0]  div_y;
  } cfg_t;

endpackage

/* sv/hti_if.sv */
// ----------------------------------------------------------------------------
// hti_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface hti_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/hti_cfg_if.sv */
// ----------------------------------------------------------------------------
// hti_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface hti_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/hti_front.sv */
// ----------------------------------------------------------------------------
// hti_front
// Maps a query point into grid units (multiply, clamp, split) or passes a
// load through; two stages feeding the command queue.
// ----------------------------------------------------------------------------
module hti_front #(
  parameter int MAX_DIV = 128,
  parameter int CW      = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hti_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hti_pkg::in_word_t in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output logic          cmd_query_o,
  output logic          cmd_null_o,
  output logic [CW-1:0] cmd_cx_o,
  output logic [CW-1:0] cmd_cy_o,
  output logic [16:0]   cmd_fx_o,
  output logic [16:0]   cmd_fy_o,
  output logic [31:0]   cmd_h_o
);
  import hti_pkg::*;

  localparam logic [CW-1:0] MaxDiv = CW'(MAX_DIV);
  localparam int LW = CW + 16;

  // stage 1: difference and product
  logic          s1_v_q, s1_q_q, s1_n_q;
  logic [CW-1:0] s1_dx_q, s1_dy_q, s1_nx_q, s1_ny_q;
  logic [31:0]   s1_h_q;
  logic [63:0]   s1_px_q, s1_py_q;
  // stage 2
  logic          s2_v_q, s2_q_q, s2_n_q;
  logic [CW-1:0] s2_cx_q, s2_cy_q;
  logic [16:0]   s2_fx_q, s2_fy_q;
  logic [31:0]   s2_h_q;

  logic adv2, adv1;
  assign adv2 = !s2_v_q || cmd_ready_i;
  assign adv1 = !s1_v_q || adv2;
  assign in_ready_o = adv1;

  logic [CW-1:0] dvx, dvy;
  logic signed [32:0] ddx, ddy;
  logic [63:0] px, py;
  always_comb begin
    dvx = (int'(cfg_i.div_x) > MAX_DIV) ? MaxDiv : CW'(cfg_i.div_x);
    dvy = (int'(cfg_i.div_y) > MAX_DIV) ? MaxDiv : CW'(cfg_i.div_y);
    ddx = $signed({in_data_i.point_x[31], in_data_i.point_x})
        - $signed({cfg_i.origin_x[31], cfg_i.origin_x});
    ddy = $signed({in_data_i.point_y[31], in_data_i.point_y})
        - $signed({cfg_i.origin_y[31], cfg_i.origin_y});
    px = (ddx <= 0) ? 64'd0 : 64'(ddx[31:0]) * 64'(cfg_i.inv_step_x);
    py = (ddy <= 0) ? 64'd0 : 64'(ddy[31:0]) * 64'(cfg_i.inv_step_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q_q  <= in_data_i.mode == MODE_QUERY;
      s1_n_q  <= (dvx == '0) || (dvy == '0);
      s1_dx_q <= dvx;
      s1_dy_q <= dvy;
      s1_nx_q <= CW'(in_data_i.node_x);
      s1_ny_q <= CW'(in_data_i.node_y);
      s1_h_q  <= in_data_i.node_height;
      s1_px_q <= px;
      s1_py_q <= py;
    end
  end

  logic [LW-1:0] lx, ly, topx, topy;
  logic [CW-1:0] cx, cy;
  always_comb begin
    topx = {s1_dx_q, 16'd0};
    topy = {s1_dy_q, 16'd0};
    lx = (s1_px_q[63:24] > 40'(topx)) ? topx : s1_px_q[24 +: LW];
    ly = (s1_py_q[63:24] > 40'(topy)) ? topy : s1_py_q[24 +: LW];
    cx = (lx[LW-1:16] > s1_dx_q - 1'b1) ? s1_dx_q - 1'b1 : lx[LW-1:16];
    cy = (ly[LW-1:16] > s1_dy_q - 1'b1) ? s1_dy_q - 1'b1 : ly[LW-1:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_q_q  <= s1_q_q;
      s2_n_q  <= s1_n_q;
      s2_h_q  <= s1_h_q;
      s2_cx_q <= s1_q_q ? cx : s1_nx_q;
      s2_cy_q <= s1_q_q ? cy : s1_ny_q;
      s2_fx_q <= 17'(lx - {cx, 16'd0});
      s2_fy_q <= 17'(ly - {cy, 16'd0});
    end
  end

  assign cmd_valid_o = s2_v_q;
  assign cmd_query_o = s2_q_q;
  assign cmd_null_o  = s2_n_q;
  assign cmd_cx_o    = s2_cx_q;
  assign cmd_cy_o    = s2_cy_q;
  assign cmd_fx_o    = s2_fx_q;
  assign cmd_fy_o    = s2_fy_q;
  assign cmd_h_o     = s2_h_q;
endmodule

/* sv/hti_queue.sv */
// ----------------------------------------------------------------------------
// hti_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module hti_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);
  logic [W-1:0] mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 3'd4;
  assign rd_valid_o = cnt_q != 3'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

/* sv/hti_back.sv */
// ----------------------------------------------------------------------------
// hti_back
// Node store in four parity banks, triangle blend, rounding and saturation.
// ----------------------------------------------------------------------------
module hti_back #(
  parameter int MAX_DIV = 128,
  parameter int CW      = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  logic          cmd_query_i,
  input  logic          cmd_null_i,
  input  logic [CW-1:0] cmd_cx_i,
  input  logic [CW-1:0] cmd_cy_i,
  input  logic [16:0]   cmd_fx_i,
  input  logic [16:0]   cmd_fy_i,
  input  logic [31:0]   cmd_h_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hti_pkg::out_word_t out_data_o
);
  import hti_pkg::*;

  localparam int HS    = MAX_DIV / 2 + 1;
  localparam int BD    = HS * HS;
  localparam int AW    = $clog2(BD);
  localparam int HW    = CW - 1;

  logic [31:0] bank_q [4][BD];

  // pipeline valid and stage flags
  logic s1_v_q, s2_v_q, s3_v_q, o_v_q;
  logic adv;
  // a free slot downstream lets the whole pipe move
  assign adv = !o_v_q || out_ready_i;
  assign cmd_ready_o = adv;

  logic acc_cmd;
  assign acc_cmd = cmd_valid_i && adv;

  // address per bank: bank index = {x parity, y parity}
  logic [HW-1:0] bx [4];
  logic [HW-1:0] by [4];
  logic [AW-1:0] ra [4];
  logic [CW-1:0] xp1, yp1;
  always_comb begin
    xp1 = cmd_cx_i + 1'b1;
    yp1 = cmd_cy_i + 1'b1;
    for (int b = 0; b < 4; b++) begin
      bx[b] = (cmd_cx_i[0] == b[1]) ? cmd_cx_i[CW-1:1] : xp1[CW-1:1];
      by[b] = (cmd_cy_i[0] == b[0]) ? cmd_cy_i[CW-1:1] : yp1[CW-1:1];
      ra[b] = AW'(32'(bx[b]) * HS + 32'(by[b]));
    end
  end

  logic ld_ok;
  logic [1:0] wb;
  assign ld_ok = acc_cmd && !cmd_query_i &&
                 (cmd_cx_i <= CW'(MAX_DIV)) && (cmd_cy_i <= CW'(MAX_DIV));
  assign wb = {cmd_cx_i[0], cmd_cy_i[0]};

  logic [31:0] rd_q [4];
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 4; b++) begin
      if (ld_ok && wb == 2'(b)) bank_q[b][ra[b]] <= cmd_h_i;
      if (acc_cmd) rd_q[b] <= bank_q[b][ra[b]];
    end
  end

  logic s1_n_q, s1_px_q, s1_py_q;
  logic [16:0] s1_fx_q, s1_fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= cmd_valid_i && cmd_query_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      o_v_q  <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_n_q  <= cmd_null_i;
      s1_px_q <= cmd_cx_i[0];
      s1_py_q <= cmd_cy_i[0];
      s1_fx_q <= cmd_fx_i;
      s1_fy_q <= cmd_fy_i;
    end
  end

  // stage 2: pick nodes and form differences
  logic signed [31:0] ha, hb, hc, hd;
  always_comb begin
    ha = rd_q[{s1_px_q, s1_py_q}];
    hb = rd_q[{s1_px_q, !s1_py_q}];
    hc = rd_q[{!s1_px_q, !s1_py_q}];
    hd = rd_q[{!s1_px_q, s1_py_q}];
  end

  logic s2_n_q, s2_up_q;
  logic signed [31:0] s2_a_q;
  logic signed [32:0] s2_d1_q, s2_d2_q;
  logic [16:0] s2_f1_q, s2_f2_q;
  logic up;
  assign up = s1_fy_q >= s1_fx_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_n_q  <= s1_n_q;
      s2_up_q <= up;
      s2_a_q  <= ha;
      s2_d1_q <= up ? (33'(hb) - 33'(ha)) : (33'(hd) - 33'(ha));
      s2_d2_q <= up ? (33'(hc) - 33'(hb)) : (33'(hc) - 33'(hd));
      s2_f1_q <= up ? s1_fy_q : s1_fx_q;
      s2_f2_q <= up ? s1_fx_q : s1_fy_q;
    end
  end

  // stage 3: products
  logic s3_n_q, s3_up_q;
  logic signed [31:0] s3_a_q;
  logic signed [50:0] s3_p1_q, s3_p2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_n_q  <= s2_n_q;
      s3_up_q <= s2_up_q;
      s3_a_q  <= s2_a_q;
      s3_p1_q <= 51'(s2_d1_q) * $signed({1'b0, s2_f1_q});
      s3_p2_q <= 51'(s2_d2_q) * $signed({1'b0, s2_f2_q});
    end
  end

  // stage 4: sum, round, saturate
  logic signed [52:0] acc;
  logic signed [36:0] hq;
  logic [31:0] hs;
  always_comb begin
    acc = (53'(s3_a_q) <<< 16) + 53'(s3_p1_q) + 53'(s3_p2_q) + 53'sd32768;
    hq  = 37'(acc >>> 16);
    if (hq > 37'sd2147483647) hs = 32'h7fffffff;
    else if (hq < -37'sd2147483648) hs = 32'h80000000;
    else hs = hq[31:0];
  end

  out_word_t o_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q.height         <= s3_n_q ? 32'd0 : hs;
      o_q.upper_triangle <= s3_n_q ? 1'b0 : s3_up_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_q;
endmodule

/* sv/heightmap_triangle_interpolator_core.sv */
// ----------------------------------------------------------------------------
// heightmap_triangle_interpolator_core
// Triangulated heightmap store and point height query.
// ----------------------------------------------------------------------------
// One item a cycle is sustained while the output is not stalled. A query
// passes the second front stage, queue, bank read, blend, multiply and round
// before its word appears; a load gives none. Four parity banks supply all
// four corner nodes of a cell in a single read. Unloaded nodes read undefined.
module heightmap_triangle_interpolator_core #(
  parameter int MAX_DIV = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  hti_cfg_if.sink cfg,
  hti_if.sink     in_ch,
  hti_if.source   out_ch
);
  import hti_pkg::*;
  `include "assert_macros.svh"

  // wide enough for any 8-bit node index as well as the grid size
  localparam int CW = (MAX_DIV < 256) ? 9 : $clog2(MAX_DIV + 2);

  cfg_t cfg_q;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{origin_x: 32'd0, origin_y: 32'd0, inv_step_x: 32'h0100_0000,
                 inv_step_y: 32'h0100_0000, div_x: 8'd0, div_y: 8'd0};
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ORIGIN_X:   cfg_q.origin_x   <= cfg.data;
        REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg.data;
        REG_INV_STEP_X: cfg_q.inv_step_x <= cfg.data;
        REG_INV_STEP_Y: cfg_q.inv_step_y <= cfg.data;
        REG_DIV_X:      cfg_q.div_x      <= cfg.data[7:0];
        REG_DIV_Y:      cfg_q.div_y      <= cfg.data[7:0];
        default:        ;
      endcase
    end
  end

  localparam int QW = 2 + 2 * CW + 34 + 32;

  logic          f_v, f_r, f_q, f_n;
  logic [CW-1:0] f_cx, f_cy;
  logic [16:0]   f_fx, f_fy;
  logic [31:0]   f_h;

  hti_front #(.MAX_DIV(MAX_DIV), .CW(CW)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_data_i(in_ch.data),
    .cmd_valid_o(f_v), .cmd_ready_i(f_r), .cmd_query_o(f_q), .cmd_null_o(f_n),
    .cmd_cx_o(f_cx), .cmd_cy_o(f_cy), .cmd_fx_o(f_fx), .cmd_fy_o(f_fy),
    .cmd_h_o(f_h)
  );

  logic          b_v, b_r, b_q, b_n;
  logic [CW-1:0] b_cx, b_cy;
  logic [16:0]   b_fx, b_fy;
  logic [31:0]   b_h;

  hti_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_v), .wr_ready_o(f_r),
    .wr_data_i({f_q, f_n, f_cx, f_cy, f_fx, f_fy, f_h}),
    .rd_valid_o(b_v), .rd_ready_i(b_r),
    .rd_data_o({b_q, b_n, b_cx, b_cy, b_fx, b_fy, b_h})
  );

  hti_back #(.MAX_DIV(MAX_DIV), .CW(CW)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_v), .cmd_ready_o(b_r), .cmd_query_i(b_q), .cmd_null_i(b_n),
    .cmd_cx_i(b_cx), .cmd_cy_i(b_cy), .cmd_fx_i(b_fx), .cmd_fy_i(b_fy),
    .cmd_h_i(b_h),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(out_ch.data)
  );

  logic cell_ok, frac_ok;
  assign cell_ok = (b_cx < CW'(MAX_DIV)) && (b_cy < CW'(MAX_DIV));
  assign frac_ok = (b_fx <= 17'h10000) && (b_fy <= 17'h10000);

  `ASSERT_IMP(a_cell_in_range, clk_i, rst_ni, b_v && b_q && !b_n, cell_ok)
  `ASSERT_IMP(a_frac_bound, clk_i, rst_ni, b_v && b_q, frac_ok)
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
endmodule

/* tb/tb_heightmap_triangle_interpolator_core.sv */
// ----------------------------------------------------------------------------
// tb_heightmap_triangle_interpolator_core
// Fills a corner of the node grid, then runs load and query words under
// several grid settings, random gaps on both sides and one long output stall.
// Each query result is checked field by field against a local predictor.
// ----------------------------------------------------------------------------
module tb_heightmap_triangle_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hti_pkg::*;

  localparam int MAX_DIV    = 128;
  localparam int SIDE       = MAX_DIV + 1;
  localparam int FILL_SIDE  = 16;
  localparam int IW         = $bits(in_word_t);
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;

  logic clk_i;
  logic rst_ni;

  hti_cfg_if                  cfg_ch ();
  hti_if #(.T(in_word_t))     in_ch ();
  hti_if #(.T(out_word_t))    out_ch ();

  heightmap_triangle_interpolator_core #(.MAX_DIV(MAX_DIV)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predictor state
  logic [31:0] node_heights [0:SIDE*SIDE-1];
  cfg_t        grid_cfg;
  out_word_t   expected_heights [$];

  int  n_errors;
  int  idle_cycles;
  int  hold_request;
  bit  no_gaps;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint unsigned to_grid(logic [31:0] p, logic [31:0] o,
                                              logic [31:0] inv, int dv);
    longint d;
    longint unsigned loc;
    longint unsigned top;
    d = longint'($signed(p)) - longint'($signed(o));
    top = longint'(dv) << 16;
    if (d <= 0) return 0;
    loc = (longint'(d) * longint'({32'd0, inv})) >> 24;
    return (loc > top) ? top : loc;
  endfunction

  function automatic out_word_t predict_height(in_word_t w);
    out_word_t r;
    int dx, dy;
    longint unsigned lx, ly, cx, cy, fx, fy;
    longint ha, hb, hc, hd, acc, h;
    dx = (grid_cfg.div_x > MAX_DIV) ? MAX_DIV : grid_cfg.div_x;
    dy = (grid_cfg.div_y > MAX_DIV) ? MAX_DIV : grid_cfg.div_y;
    r = '0;
    if (dx == 0 || dy == 0) return r;
    lx = to_grid(w.point_x, grid_cfg.origin_x, grid_cfg.inv_step_x, dx);
    ly = to_grid(w.point_y, grid_cfg.origin_y, grid_cfg.inv_step_y, dy);
    cx = lx >> 16;
    cy = ly >> 16;
    if (cx > dx - 1) cx = dx - 1;
    if (cy > dy - 1) cy = dy - 1;
    fx = lx - (cx << 16);
    fy = ly - (cy << 16);
    ha = longint'($signed(node_heights[cx*SIDE + cy]));
    hb = longint'($signed(node_heights[cx*SIDE + cy + 1]));
    hc = longint'($signed(node_heights[(cx+1)*SIDE + cy + 1]));
    hd = longint'($signed(node_heights[(cx+1)*SIDE + cy]));
    r.upper_triangle = (fy >= fx);
    if (r.upper_triangle)
      acc = ha*65536 + longint'(fy)*(hb - ha) + longint'(fx)*(hc - hb);
    else
      acc = ha*65536 + longint'(fx)*(hd - ha) + longint'(fy)*(hc - hd);
    h = (acc + 32768) >>> 16;
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    r.height = h[31:0];
    return r;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    if (w.mode == MODE_QUERY)
      expected_heights.push_back(predict_height(w));
    else if (w.node_x <= MAX_DIV && w.node_y <= MAX_DIV)
      node_heights[w.node_x*SIDE + w.node_y] = w.node_height;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_node(int x, int y, logic [31:0] hgt);
    in_word_t w;
    w = in_word_t'(IW'({$urandom, $urandom, $urandom, $urandom}));
    w.mode = MODE_LOAD;
    w.node_x = x[7:0];
    w.node_y = y[7:0];
    w.node_height = hgt;
    send_word(w);
  endtask

  task automatic query_point(logic [31:0] px, logic [31:0] py);
    in_word_t w;
    w = in_word_t'(IW'({$urandom, $urandom, $urandom, $urandom}));
    w.mode = MODE_QUERY;
    w.point_x = px;
    w.point_y = py;
    send_word(w);
  endtask

  // loads that do not produce a word may still be in flight, hence the pause
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X:   grid_cfg.origin_x   = val;
      REG_ORIGIN_Y:   grid_cfg.origin_y   = val;
      REG_INV_STEP_X: grid_cfg.inv_step_x = val;
      REG_INV_STEP_Y: grid_cfg.inv_step_y = val;
      REG_DIV_X:      grid_cfg.div_x      = val[7:0];
      default:        grid_cfg.div_y      = val[7:0];
    endcase
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] ix,
                          logic [31:0] iy, logic [7:0] dvx, logic [7:0] dvy);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_STEP_X, ix);
    write_reg(REG_INV_STEP_Y, iy);
    write_reg(REG_DIV_X, {24'd0, dvx});
    write_reg(REG_DIV_Y, {24'd0, dvy});
  endtask

  // point near the grid span along one axis, sometimes anywhere
  function automatic logic [31:0] near_grid(logic [31:0] o, logic [31:0] inv,
                                            logic [7:0] dv);
    longint span, off;
    int d;
    d = (dv > MAX_DIV) ? MAX_DIV : dv;
    if (inv == 0 || $urandom_range(0, 9) == 0) return $urandom;
    span = (longint'(d) << 40) / longint'({32'd0, inv});
    if (span > 64'sd1_000_000_000) span = 64'sd1_000_000_000;
    off = longint'($urandom_range(0, 99999)) * (span + span/4 + 1) / 100000 - span/8;
    return o + off[31:0];
  endfunction

  task automatic random_words(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 7) == 0)
          load_node($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        else
          load_node($urandom_range(0, MAX_DIV), $urandom_range(0, MAX_DIV), $urandom);
      end else begin
        query_point(near_grid(grid_cfg.origin_x, grid_cfg.inv_step_x, grid_cfg.div_x),
                    near_grid(grid_cfg.origin_y, grid_cfg.inv_step_y, grid_cfg.div_y));
      end
    end
  endtask

  task automatic test_no_surface();
    query_point(32'h0001_0000, 32'h0001_0000);
    query_point(32'h8000_0000, 32'h7fff_ffff);
    set_grid(0, 0, 32'h0100_0000, 32'h0100_0000, 8'd4, 8'd0);
    query_point(32'h0001_8000, 32'h0000_4000);
  endtask

  task automatic fill_grid();
    logic [31:0] hgt;
    for (int x = 0; x <= FILL_SIDE; x++)
      for (int y = 0; y <= FILL_SIDE; y++) begin
        case ($urandom_range(0, 15))
          0:       hgt = 32'h7fff_ffff;
          1:       hgt = 32'h8000_0000;
          2, 3, 4: hgt = $urandom;
          default: hgt = $urandom_range(0, 2000000) - 1000000;
        endcase
        load_node(x, y, hgt);
      end
  endtask

  task automatic test_directed();
    set_grid(0, 0, 32'h0100_0000, 32'h0100_0000, 8'd4, 8'd4);
    load_node(0, 0, 32'h7fff_ffff);
    load_node(0, 1, 32'h8000_0000);
    load_node(1, 1, 32'h7fff_ffff);
    load_node(1, 0, 32'h8000_0000);
    load_node(127, 0, 32'h0012_3400);
    load_node(127, 1, 32'hffed_cc00);
    load_node(128, 0, 32'h7fff_ffff);
    load_node(128, 1, 32'h8000_0000);
    load_node(129, 0, 32'h1234_5678);
    load_node(255, 255, 32'hffff_ffff);
    query_point(32'hffff_0000, 32'hffff_0000);
    query_point(32'h0000_0000, 32'h0000_0000);
    query_point(32'h0000_8000, 32'h0000_8000);
    query_point(32'h0000_8000, 32'h0000_4000);
    query_point(32'h0000_4000, 32'h0000_8000);
    query_point(32'h0000_ffff, 32'h0000_0001);
    query_point(32'h0002_0000, 32'h0003_0000);
    query_point(32'h0004_0000, 32'h0004_0000);
    query_point(32'h7fff_ffff, 32'h7fff_ffff);
    query_point(32'h8000_0000, 32'h7fff_ffff);
    set_grid(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 8'd1, 8'd1);
    query_point(32'h7fff_ffff, 32'h7fff_ffff);
    query_point(32'h8000_0000, 32'h8000_0000);
    set_grid(32'hfff0_0000, 32'h0, 32'hffff_ffff, 32'h0, 8'd255, 8'd128);
    query_point(32'h7fff_ffff, 32'h0040_0000);
    query_point(32'hfff0_0001, 32'h8000_0000);
  endtask

  task automatic test_random();
    logic [31:0] inv_pick [4];
    logic [7:0]  dvx, dvy;
    for (int phase = 0; phase < 6; phase++) begin
      inv_pick = '{32'h0100_0000, 32'h0040_0000, 32'h0400_0000, $urandom};
      dvx = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, FILL_SIDE));
      dvy = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, FILL_SIDE));
      set_grid($urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
               inv_pick[$urandom_range(0, 3)], inv_pick[$urandom_range(0, 3)], dvx, dvy);
      no_gaps = (phase % 3 == 2);
      random_words(200);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    set_grid(0, 0, 32'h0100_0000, 32'h0080_0000, 8'd16, 8'd8);
    no_gaps = 1'b1;
    hold_request = 300;
    random_words(200);
    no_gaps = 1'b0;
  endtask

  // result checker and output-side stalls
  initial begin
    int hold;
    out_word_t exp_w;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (expected_heights.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected word: height %h upper %b",
                                       out_ch.data.height, out_ch.data.upper_triangle);
        end else begin
          exp_w = expected_heights.pop_front();
          if (out_ch.data.height !== exp_w.height ||
              out_ch.data.upper_triangle !== exp_w.upper_triangle) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected height %h upper %b, got height %h upper %b",
                       exp_w.height, exp_w.upper_triangle,
                       out_ch.data.height, out_ch.data.upper_triangle);
          end
        end
      end
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (pick_gap() > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_heightmap_triangle_interpolator_core: errors");
      $finish;
    end
  end

  initial begin
    n_errors     = 0;
    idle_cycles  = 0;
    hold_request = 0;
    no_gaps      = 1'b0;
    grid_cfg     = '{32'd0, 32'd0, 32'h0100_0000, 32'h0100_0000, 8'd0, 8'd0};
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ORIGIN_X;
    cfg_ch.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_surface();
    wait_idle();
    fill_grid();
    test_directed();
    test_random();
    test_backpressure();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && expected_heights.size() == 0) begin
      $display("tb_heightmap_triangle_interpolator_core: clean");
    end else begin
      $display("tb_heightmap_triangle_interpolator_core: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/hti_pkg.sv
sv/hti_if.sv
sv/hti_cfg_if.sv
sv/hti_front.sv
sv/hti_queue.sv
sv/hti_back.sv
sv/heightmap_triangle_interpolator_core.sv
tb/tb_heightmap_triangle_interpolator_core.sv
